@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ sv/tqm_pkg.sv @@
// Types, codes and helpers shared by the timer queue manager files.
package tqm_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RIDX_W          = $clog2(MAX_RESULTS);
    localparam int RCNT_W          = RIDX_W + 1;
    localparam int IN_W            = 104;
    localparam int OUT_W           = 104;

    // Operation codes.
    localparam logic [2:0] OP_ADD_ONCE   = 3'd0;
    localparam logic [2:0] OP_ADD_REPEAT = 3'd1;
    localparam logic [2:0] OP_CANCEL     = 3'd2;
    localparam logic [2:0] OP_REFRESH    = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;
    localparam logic [2:0] OP_QUERY      = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NONE_DUE  = 2'd3;

    // One timer slot as stored in the slot memory.
    typedef struct packed {
        logic        repeat_en;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [63:0] id;
    } slot_t;

    // One expiry report as stored in the result buffer.
    typedef struct packed {
        logic        rearmed;
        logic [63:0] id;
    } report_t;

    // Unsigned add that saturates at all ones.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ sv/tqm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module tqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/timer_queue_manager_top.sv @@
// Timer queue manager: slot table scanned by one shared compare unit.
//
//  Channel | Direction | Contents
//  s_axis  | in        | tdata: operation, timer_id, delay_ticks
//  m_axis  | out       | tdata: result fields, tlast: final result of an operation
//
// Each pass reads the slot memory at one slot a cycle, over all TIMER_SLOTS slots.
// Add, cancel, refresh and query run a lookup pass and an earliest-deadline pass, then give
// one result and return to idle; unused codes skip the lookup and run only the second pass.
// A tick runs one pick pass per expired timer until a pass finds nothing due or MAX_RESULTS
// are reported, then an earliest-deadline pass. Receiver stalls lengthen result transfers.
// The input is not ready from acceptance until the last result transfer completes.
// Reset clears the time counter and all slot valid bits at once; no clearing pass is needed.
module timer_queue_manager_top #(
    parameter int TIMER_SLOTS = tqm_pkg::TIMER_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // operation[2:0], timer_id[66:3], delay_ticks[98:67], zero fill
    input  logic [tqm_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // expired_id[63:0], rearmed[64], found[65], status[67:66],
    // next_deadline[99:68], deadline_valid[100], zero fill
    output logic [tqm_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    import tqm_pkg::*;

    localparam int IDX_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_LD, S_OUT} state_t;
    typedef enum logic [1:0] {M_FIND, M_PICK, M_EARLY} mode_t;

    state_t                 state_reg;
    mode_t                  mode_reg;
    logic [2:0]             op_reg;
    logic [63:0]            id_reg;
    logic [31:0]            delay_reg;
    logic [31:0]            time_reg;
    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [TIMER_SLOTS-1:0] chosen_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   pipe_vld_reg;
    logic [IDX_W-1:0]       pipe_idx_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    slot_t                  hit_slot_reg;
    logic                   best_any_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    slot_t                  best_slot_reg;
    logic [RCNT_W-1:0]      n_reg;
    logic [RCNT_W-1:0]      k_reg;
    logic                   res_found_reg;
    logic [1:0]             res_status_reg;
    logic [63:0]            out_id_reg;
    logic                   out_rearm_reg;
    logic                   out_found_reg;
    logic [1:0]             out_status_reg;
    logic                   out_last_reg;
    logic [31:0]            nd_reg;
    logic                   dv_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    slot_t                  ram_wdata;
    slot_t                  ram_rdata;
    logic                   buf_we;
    report_t                buf_wdata;
    report_t                buf_rdata;
    logic                   in_fire;
    logic                   scan_done;
    logic                   free_any;
    logic [IDX_W-1:0]       free_idx;
    logic                   cand;
    logic                   better;

    // Slot memory and result buffer.
    tqm_ram #(.WIDTH($bits(slot_t)), .DEPTH(TIMER_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    tqm_ram #(.WIDTH($bits(report_t)), .DEPTH(MAX_RESULTS)) u_report_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (n_reg[RIDX_W-1:0]),
        .wdata (buf_wdata),
        .raddr (k_reg[RIDX_W-1:0]),
        .rdata (buf_rdata)
    );

    // Handshake and scan status.
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign scan_done     = (state_reg == S_SCAN) && (cnt_reg == CNT_W'(TIMER_SLOTS))
                           && !pipe_vld_reg;

    // Lowest free slot.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Shared compare unit applied to the slot read back in this cycle.
    always_comb
    begin
        cand   = 1'b0;
        better = 1'b0;
        case (mode_reg)
            M_PICK:
            begin
                cand   = valid_reg[pipe_idx_reg] && !chosen_reg[pipe_idx_reg]
                         && (ram_rdata.deadline <= time_reg);
                better = !best_any_reg || (ram_rdata.deadline < best_slot_reg.deadline)
                         || ((ram_rdata.deadline == best_slot_reg.deadline)
                             && (ram_rdata.id < best_slot_reg.id));
            end
            M_EARLY:
            begin
                cand   = valid_reg[pipe_idx_reg];
                better = !best_any_reg || (ram_rdata.deadline < best_slot_reg.deadline);
            end
            default:
            begin
                cand   = valid_reg[pipe_idx_reg] && (ram_rdata.id == id_reg);
                better = !hit_reg;
            end
        endcase
    end

    // Slot and report writes made at the end of a pass.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = best_slot_reg;
        buf_we    = 1'b0;
        buf_wdata = '{rearmed: best_slot_reg.repeat_en, id: best_slot_reg.id};
        if (scan_done && (mode_reg == M_FIND))
        begin
            case (op_reg)
                OP_ADD_ONCE, OP_ADD_REPEAT:
                begin
                    ram_we    = hit_reg || free_any;
                    ram_waddr = hit_reg ? hit_idx_reg : free_idx;
                    ram_wdata = '{repeat_en: (op_reg == OP_ADD_REPEAT), period: delay_reg,
                                  deadline: sat_add(time_reg, delay_reg), id: id_reg};
                end
                OP_REFRESH:
                begin
                    ram_we    = hit_reg;
                    ram_waddr = hit_idx_reg;
                    ram_wdata = hit_slot_reg;
                    ram_wdata.deadline = sat_add(time_reg, hit_slot_reg.period);
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
        else if (scan_done && (mode_reg == M_PICK) && best_any_reg)
        begin
            buf_we             = 1'b1;
            ram_we             = best_slot_reg.repeat_en;
            ram_waddr          = best_idx_reg;
            ram_wdata.deadline = sat_add(time_reg, best_slot_reg.period);
        end
    end

    // Sequencer, scan registers and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_FIND;
            time_reg       <= '0;
            valid_reg      <= '0;
            chosen_reg     <= '0;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            best_any_reg   <= 1'b0;
            n_reg          <= '0;
            k_reg          <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
            op_reg         <= '0;
        end
        else
        begin
            // Address issue and compare pipeline of a pass.
            if (state_reg == S_SCAN)
            begin
                if (cnt_reg != CNT_W'(TIMER_SLOTS))
                begin
                    pipe_vld_reg <= 1'b1;
                    pipe_idx_reg <= cnt_reg[IDX_W-1:0];
                    cnt_reg      <= cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pipe_vld_reg <= 1'b0;
                end
                if (pipe_vld_reg && cand && better)
                begin
                    if (mode_reg == M_FIND)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= pipe_idx_reg;
                        hit_slot_reg <= ram_rdata;
                    end
                    else
                    begin
                        best_any_reg  <= 1'b1;
                        best_idx_reg  <= pipe_idx_reg;
                        best_slot_reg <= ram_rdata;
                    end
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg         <= s_axis_tdata[2:0];
                        id_reg         <= s_axis_tdata[66:3];
                        delay_reg      <= s_axis_tdata[98:67];
                        res_found_reg  <= 1'b0;
                        res_status_reg <= (s_axis_tdata[2:0] == OP_TICK) ? ST_NONE_DUE : ST_OK;
                        n_reg          <= '0;
                        chosen_reg     <= '0;
                        cnt_reg        <= '0;
                        hit_reg        <= 1'b0;
                        best_any_reg   <= 1'b0;
                        state_reg      <= S_SCAN;
                        case (s_axis_tdata[2:0])
                            OP_TICK:
                            begin
                                time_reg <= time_reg + 32'd1;
                                mode_reg <= M_PICK;
                            end
                            OP_ADD_ONCE, OP_ADD_REPEAT, OP_CANCEL, OP_REFRESH, OP_QUERY:
                            begin
                                mode_reg <= M_FIND;
                            end
                            default:
                            begin
                                mode_reg <= M_EARLY;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        cnt_reg      <= '0;
                        best_any_reg <= 1'b0;
                        case (mode_reg)
                            M_FIND:
                            begin
                                mode_reg <= M_EARLY;
                                case (op_reg)
                                    OP_ADD_ONCE, OP_ADD_REPEAT:
                                    begin
                                        if (hit_reg)
                                        begin
                                            valid_reg[hit_idx_reg] <= 1'b1;
                                        end
                                        else if (free_any)
                                        begin
                                            valid_reg[free_idx] <= 1'b1;
                                        end
                                        else
                                        begin
                                            res_status_reg <= ST_FULL;
                                        end
                                    end
                                    default:
                                    begin
                                        res_found_reg  <= hit_reg;
                                        res_status_reg <= hit_reg ? ST_OK : ST_NOT_FOUND;
                                        if (hit_reg && (op_reg == OP_CANCEL))
                                        begin
                                            valid_reg[hit_idx_reg] <= 1'b0;
                                        end
                                    end
                                endcase
                            end
                            M_PICK:
                            begin
                                if (best_any_reg)
                                begin
                                    chosen_reg[best_idx_reg] <= 1'b1;
                                    if (!best_slot_reg.repeat_en)
                                    begin
                                        valid_reg[best_idx_reg] <= 1'b0;
                                    end
                                    n_reg <= n_reg + RCNT_W'(1);
                                    if (n_reg + RCNT_W'(1) == RCNT_W'(MAX_RESULTS))
                                    begin
                                        mode_reg <= M_EARLY;
                                    end
                                end
                                else
                                begin
                                    mode_reg <= M_EARLY;
                                end
                            end
                            default:
                            begin
                                nd_reg <= best_any_reg ? best_slot_reg.deadline : 32'd0;
                                dv_reg <= best_any_reg;
                                k_reg  <= '0;
                                if ((op_reg == OP_TICK) && (n_reg != '0))
                                begin
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    out_id_reg     <= '0;
                                    out_rearm_reg  <= 1'b0;
                                    out_found_reg  <= res_found_reg;
                                    out_status_reg <= res_status_reg;
                                    out_last_reg   <= 1'b1;
                                    state_reg      <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LD;
                end
                S_LD:
                begin
                    out_id_reg     <= buf_rdata.id;
                    out_rearm_reg  <= buf_rdata.rearmed;
                    out_found_reg  <= 1'b0;
                    out_status_reg <= ST_OK;
                    out_last_reg   <= (k_reg + RCNT_W'(1)) == n_reg;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (out_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + RCNT_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result transfer payload.
    assign m_axis_tdata = {3'b000, dv_reg, nd_reg, out_status_reg, out_found_reg,
                           out_rearm_reg, out_id_reg};
    assign m_axis_tlast = out_last_reg;

endmodule

@@ sv/tqm_checker.sv @@
// Port-level checks for the timer queue manager, bound to the top level.
`include "assert_macros.svh"

module tqm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [tqm_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    import tqm_pkg::*;

    // One operation at a time: no input while results are pending.
    `ASSERT_NEVER(a_no_input_during_output, m_axis_tvalid && s_axis_tready)

    // An accepted operation blocks the input on the next cycle.
    `ASSERT_CLK(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // A stalled result holds.
    `ASSERT_CLK(a_stall_holds, m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // A tick with nothing due gives a single result.
    `ASSERT_CLK(a_none_due_is_last, m_axis_tvalid && (m_axis_tdata[67:66] == ST_NONE_DUE)
        |-> m_axis_tlast)

    // A re-armed report is an expiry report.
    `ASSERT_CLK(a_rearm_is_expiry, m_axis_tvalid && m_axis_tdata[64] |->
        (m_axis_tdata[67:66] == ST_OK) && !m_axis_tdata[65])

endmodule

bind timer_queue_manager_top tqm_checker u_tqm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
